// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

   localparam int MEXP_WIDTH = 32;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_EXPONENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MODULUS  = 2'd1;

   localparam logic [DATA_W-1:0] RESET_EXPONENT = 32'd3;
   localparam logic [DATA_W-1:0] RESET_MODULUS  = 32'd3233;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PICK_SUM,
      PICK_SUB1,
      PICK_SUB2
   } pick_type;

   typedef struct packed {
      logic     clear;
      logic     enable;
      logic     bsel;
      pick_type pick;
   } cell_ctl_type;

   typedef struct packed {
      logic add;
      logic sub1;
      logic sub2;
   } carry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_cell
   import mexp_pkg::*;
(
   input  wire          clock,
   input  cell_ctl_type ctl,
   input  wire          r_prev,
   input  wire          a_bit,
   input  wire          m_bit,
   input  wire          m_prev,
   input  carry_type    cy_in,
   output carry_type    cy_out,
   output logic         r_bit
);

   logic r_ff;
   logic r_in;
   logic addend;
   logic s_bit;
   logic d1_bit;
   logic d2_bit;

   always_comb begin
      addend        = a_bit & ctl.bsel;
      s_bit         = r_prev ^ addend ^ cy_in.add;
      cy_out.add    = (r_prev & addend) | (r_prev & cy_in.add) | (addend & cy_in.add);
      d1_bit        = s_bit ^ m_bit ^ cy_in.sub1;
      cy_out.sub1   = (~s_bit & m_bit) | (~s_bit & cy_in.sub1) | (m_bit & cy_in.sub1);
      d2_bit        = s_bit ^ m_prev ^ cy_in.sub2;
      cy_out.sub2   = (~s_bit & m_prev) | (~s_bit & cy_in.sub2) | (m_prev & cy_in.sub2);
      case (ctl.pick)
         PICK_SUM:  r_in = s_bit;
         PICK_SUB1: r_in = d1_bit;
         PICK_SUB2: r_in = d2_bit;
         default:   r_in = s_bit;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         r_ff <= 1'b0;
      end else if (ctl.enable) begin
         r_ff <= r_in;
      end
   end

   assign r_bit = r_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int W = MEXP_WIDTH
)
(
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire  [W-1:0] opnd_a,
   input  wire  [W-1:0] opnd_b,
   input  wire  [W-1:0] modulus,
   output mm_stat_type  stat,
   output logic [W-1:0] result
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     b_sh_ff, b_sh_in;

   cell_ctl_type ctl;
   carry_type    cy [W+1];
   logic [W-1:0] r_bits;
   logic [1:0]   hi;
   logic [1:0]   sub2_need;
   logic         neg1;
   logic         neg2;

   // The top two bits of 2r + a sit above the cell row.
   always_comb begin
      hi        = {1'b0, r_bits[W-1]} + {1'b0, cy[W].add};
      sub2_need = {1'b0, modulus[W-1]} + {1'b0, cy[W].sub2};
      neg1      = (hi == 2'd0) && cy[W].sub1;
      neg2      = hi < sub2_need;
      ctl.clear  = start;
      ctl.enable = busy_ff;
      ctl.bsel   = b_sh_ff[W-1];
      if (!neg2) begin
         ctl.pick = PICK_SUB2;
      end else if (!neg1) begin
         ctl.pick = PICK_SUB1;
      end else begin
         ctl.pick = PICK_SUM;
      end
   end

   assign cy[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      mexp_cell u_cell (
         .clock  (clock),
         .ctl    (ctl),
         .r_prev ((i == 0) ? 1'b0 : r_bits[(i == 0) ? 0 : i - 1]),
         .a_bit  (opnd_a[i]),
         .m_bit  (modulus[i]),
         .m_prev ((i == 0) ? 1'b0 : modulus[(i == 0) ? 0 : i - 1]),
         .cy_in  (cy[i]),
         .cy_out (cy[i+1]),
         .r_bit  (r_bits[i])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      b_sh_in = b_sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W);
         b_sh_in = opnd_b;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         b_sh_in = {b_sh_ff[W-2:0], 1'b0};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_sh_ff <= b_sh_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = r_bits;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                              Contents
// req       in         req_tvalid/tready/tdata[31:0]      message_value
// rsp       out        rsp_tvalid/tready/tdata[31:0]      power_result
// csr       in         csr_valid/ready/index[1:0]/data    key_exponent (0), key_modulus (1)
//
// Each modular product runs through the cell row, scanning the second operand from its top bit.
// An item needs one reduction, OPERAND_WIDTH - 1 squarings and one product per set
// exponent bit.
// A new transaction is taken while the previous result waits in the output register.
// Synchronous reset restores the key registers to exponent 3 and modulus 3233.

module modular_exponentiation_core
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = MEXP_WIDTH
)
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [DATA_W-1:0]    req_tdata,   // [31:0] message_value
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] power_result
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [DATA_W-1:0]    csr_data
);

   localparam int W     = OPERAND_WIDTH;
   localparam int BIT_W = $clog2(W);
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(W - 1);

   state_type state_ff, state_in;
   logic      first_ff, first_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [BIT_W-1:0] next_bit;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [W-1:0] key_exponent_ff;
   logic [W-1:0] key_modulus_ff;
   logic [W-1:0] msg_ff;
   logic [W-1:0] acc_ff;
   logic [W-1:0] sq_ff;
   logic [W-1:0] one_mod;
   logic [W-1:0] final_value;

   logic         accept;
   logic         out_load;
   logic         mm_start;
   logic [W-1:0] op_a;
   logic [W-1:0] op_b;
   mm_stat_type  mm_stat;
   logic [W-1:0] mm_result;

   function automatic state_type dispatch(input logic ebit, input logic last);
      state_type s;
      if (ebit) begin
         s = ST_MULT;
      end else if (last) begin
         s = ST_FINISH;
      end else begin
         s = ST_SQUARE;
      end
      return s;
   endfunction

   assign one_mod     = (key_modulus_ff == W'(1)) ? '0 : W'(1);
   assign final_value = (key_modulus_ff == '0) ? '0 : acc_ff;
   assign accept      = req_tvalid && req_tready;
   assign next_bit    = bit_ff + BIT_W'(1);

   always_comb begin
      state_in = state_ff;
      first_in = 1'b0;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REDUCE;
               first_in = 1'b1;
               bit_in   = '0;
            end
         end
         ST_REDUCE: begin
            if (mm_stat.done) begin
               state_in = dispatch(key_exponent_ff[0], 1'b0);
               first_in = 1'b1;
            end
         end
         ST_MULT: begin
            if (mm_stat.done) begin
               state_in = (bit_ff == LAST_BIT) ? ST_FINISH : ST_SQUARE;
               first_in = 1'b1;
            end
         end
         ST_SQUARE: begin
            if (mm_stat.done) begin
               bit_in   = next_bit;
               state_in = dispatch(key_exponent_ff[next_bit], next_bit == LAST_BIT);
               first_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      mm_start   = 1'b0;
      op_a       = sq_ff;
      op_b       = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_REDUCE: begin
            mm_start = first_ff;
            op_a     = one_mod;
            op_b     = msg_ff;
         end
         ST_MULT: begin
            mm_start = first_ff;
            op_b     = acc_ff;
         end
         ST_SQUARE: begin
            mm_start = first_ff;
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   mexp_mulmod #(
      .W (W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .opnd_a  (op_a),
      .opnd_b  (op_b),
      .modulus (key_modulus_ff),
      .stat    (mm_stat),
      .result  (mm_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_ff        <= 1'b0;
         bit_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         key_exponent_ff <= RESET_EXPONENT[W-1:0];
         key_modulus_ff  <= RESET_MODULUS[W-1:0];
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEY_EXPONENT: key_exponent_ff <= csr_data[W-1:0];
               REG_KEY_MODULUS:  key_modulus_ff  <= csr_data[W-1:0];
               default:          key_exponent_ff <= key_exponent_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         msg_ff <= req_tdata[W-1:0];
         acc_ff <= one_mod;
      end else if (mm_stat.done && state_ff == ST_MULT) begin
         acc_ff <= mm_result;
      end
      if (mm_stat.done && (state_ff == ST_REDUCE || state_ff == ST_SQUARE)) begin
         sq_ff <= mm_result;
      end
      if (out_load) begin
         rsp_data_ff <= DATA_W'(final_value);
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken but block stayed idle");

   a_done_in_compute: assert property (@(posedge clock) disable iff (reset)
      mm_stat.done |-> (state_ff == ST_REDUCE || state_ff == ST_MULT ||
                        state_ff == ST_SQUARE))
      else $error("modular product finished outside a compute state");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_stat.busy)
      else $error("modular product started while busy");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("result loaded but not presented");

endmodule

`default_nettype wire

// ===== tb/sv/tb_modular_exponentiation_core.sv =====
`timescale 1ns / 1ps

module tb_modular_exponentiation_core;
   import mexp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int DIRECTED_TAIL = 2500;
   localparam int RANDOM_ITEMS  = 270;

   typedef enum int {
      READY_ALWAYS,
      READY_SPARSE,
      READY_LONG_STALLS
   } ready_mode_e;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   logic [DATA_W-1:0] active_exponent = RESET_EXPONENT;
   logic [DATA_W-1:0] active_modulus  = RESET_MODULUS;

   logic [DATA_W-1:0] msg_queue[$];
   logic [DATA_W-1:0] power_queue[$];
   logic [DATA_W-1:0] want_power;
   int                errors = 0;

   int          burst_left;
   int          gap_left;
   int          gap_draw;
   int          stall_left;
   int          mode_cycles;
   ready_mode_e ready_mode;

   modular_exponentiation_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [DATA_W-1:0] power_mod(input logic [DATA_W-1:0] base,
                                                   input logic [DATA_W-1:0] expo,
                                                   input logic [DATA_W-1:0] modulus);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] m;
      if (modulus == '0) begin
         return '0;
      end
      m   = {32'd0, modulus};
      acc = 64'd1 % m;
      sq  = {32'd0, base} % m;
      for (int b = 0; b < MEXP_WIDTH; b++) begin
         if (expo[b]) begin
            acc = (acc * sq) % m;
         end
         sq = (sq * sq) % m;
      end
      return acc[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] pick_exponent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 | $urandom;
         3: return $urandom_range(1, 65537);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_modulus();
      case ($urandom_range(0, 19))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom_range(2, 4096);
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_message(input logic [DATA_W-1:0] modulus);
      case ($urandom_range(0, 11))
         7: return '0;
         8: return 32'hFFFF_FFFF;
         9: return (modulus != '0) ? ($urandom % modulus) : $urandom;
         10: return modulus;
         11: return modulus - 1'b1;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_KEY_EXPONENT) begin
         active_exponent = value;
      end else if (idx == REG_KEY_MODULUS) begin
         active_modulus = value;
      end
   endtask

   // Sampled at the falling edge so that the sender's updates from the rising edge are seen.
   task automatic drain();
      while (msg_queue.size() != 0 || req_tvalid || power_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The sender runs in bursts; a transaction that is offered stays offered until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            power_queue.push_back(power_mod(req_tdata, active_exponent, active_modulus));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (msg_queue.size() != 0) begin
               req_tdata  <= msg_queue.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 7);
                  gap_draw   = $urandom_range(0, 19);
                  if (gap_draw < 10) begin
                     gap_left = 0;
                  end else if (gap_draw < 17) begin
                     gap_left = $urandom_range(1, 8);
                  end else begin
                     gap_left = $urandom_range(1, 2200);
                  end
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
         mode_cycles = 0;
         ready_mode  = READY_ALWAYS;
      end else begin
         if (mode_cycles == 0) begin
            ready_mode  = ready_mode_e'($urandom_range(0, 2));
            mode_cycles = $urandom_range(2000, 8000);
         end else begin
            mode_cycles--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 2) != 0);
               default: begin
                  if ($urandom_range(0, 299) == 0) begin
                     stall_left = $urandom_range(1, 1500);
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (power_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want_power = power_queue.pop_front();
            if (rsp_tdata !== want_power) begin
               $display("%0t: power_result mismatch, expected %h, actual %h",
                        $time, want_power, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      #80_000_000;
      $display("tb_modular_exponentiation_core NOT OK");
      $finish;
   end

   initial begin
      int remaining;
      int batch;
      int choice;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      msg_queue.push_back(32'd0);
      msg_queue.push_back(32'd1);
      msg_queue.push_back(32'd3232);
      msg_queue.push_back(32'd3233);
      msg_queue.push_back(32'hFFFF_FFFF);
      msg_queue.push_back(32'd123);
      drain();

      write_key(REG_KEY_EXPONENT, 32'd17);
      msg_queue.push_back(32'd65);
      drain();
      write_key(REG_KEY_EXPONENT, 32'd2753);
      msg_queue.push_back(32'd2790);
      drain();

      write_key(REG_KEY_EXPONENT, 32'd0);
      write_key(REG_KEY_MODULUS, 32'hFFFF_FFFF);
      msg_queue.push_back(32'd0);
      msg_queue.push_back(32'd5);
      drain();

      write_key(REG_KEY_EXPONENT, 32'hFFFF_FFFF);
      msg_queue.push_back(32'hFFFF_FFFE);
      msg_queue.push_back(32'd2);
      drain();

      write_key(REG_KEY_EXPONENT, 32'h8000_0000);
      write_key(REG_KEY_MODULUS, 32'hFFFF_FFFB);
      msg_queue.push_back(32'd3);
      msg_queue.push_back(32'hFFFF_FFFF);
      drain();

      write_key(REG_KEY_MODULUS, 32'd1);
      write_key(REG_KEY_EXPONENT, $urandom);
      msg_queue.push_back(32'd7);
      drain();
      write_key(REG_KEY_EXPONENT, 32'd0);
      msg_queue.push_back(32'd4);
      drain();

      write_key(REG_KEY_MODULUS, 32'd0);
      write_key(REG_KEY_EXPONENT, 32'd5);
      msg_queue.push_back(32'd9);
      msg_queue.push_back(32'hFFFF_FFFF);
      drain();

      // Writes to the unused indexes must leave both keys untouched.
      write_key(REG_KEY_MODULUS, 32'd3233);
      write_key(CSR_SPARE_A, $urandom);
      write_key(CSR_SPARE_B, $urandom);
      msg_queue.push_back(32'd1234);
      drain();

      remaining = RANDOM_ITEMS;
      while (remaining > 0) begin
         batch = $urandom_range(8, 30);
         if (batch > remaining) begin
            batch = remaining;
         end
         choice = $urandom_range(0, 5);
         if (choice != 1) begin
            write_key(REG_KEY_EXPONENT, pick_exponent());
         end
         if (choice != 2) begin
            write_key(REG_KEY_MODULUS, pick_modulus());
         end
         if (choice == 3) begin
            write_key($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
         end
         repeat (batch) msg_queue.push_back(pick_message(active_modulus));
         remaining -= batch;
         drain();
      end

      repeat (DIRECTED_TAIL) @(posedge clock);
      if (errors == 0) begin
         $display("tb_modular_exponentiation_core OK");
      end else begin
         $display("tb_modular_exponentiation_core NOT OK");
      end
      $finish;
   end

endmodule
